>>> rtl/b64se_pkg.sv
// Shared types and constants for the Base64 stream encoder.
// Depends on nothing; the other RTL files except b64se_if refer to it by scoped names.
`default_nettype none

package b64se_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [6:0] char_type;
   typedef logic [5:0] sextet_type;
   typedef logic [1:0] phase_type;
   typedef logic [3:0] leftover_type;
   typedef logic [1:0] slot_type;

   // Place of the next byte in its three-byte group
   localparam phase_type PHASE_FIRST  = 2'd0;
   localparam phase_type PHASE_SECOND = 2'd1;
   localparam phase_type PHASE_THIRD  = 2'd2;

   localparam char_type CHAR_PAD   = 7'd61;  // '='
   localparam char_type CHAR_PLUS  = 7'd43;  // '+'
   localparam char_type CHAR_SLASH = 7'd47;  // '/'

   localparam sextet_type SEXTET_PLUS  = 6'd62;
   localparam sextet_type SEXTET_SLASH = 6'd63;

   // Characters that one byte produces, oldest in slot 0
   typedef struct packed {
      char_type [3:0] codes;
      slot_type       last_slot;
      logic           fin;
   } job_type;

   // Map a 6-bit value onto the standard alphabet
   function automatic char_type sym(input sextet_type six);
      char_type code;
      code = CHAR_PAD;
      if (six < 6'd26) begin
         code = 7'd65 + {1'b0, six};
      end else if (six < 6'd52) begin
         code = 7'd71 + {1'b0, six};
      end else if (six < SEXTET_PLUS) begin
         code = {1'b0, six} - 7'd4;
      end else if (six == SEXTET_PLUS) begin
         code = CHAR_PLUS;
      end else begin
         code = CHAR_SLASH;
      end
      return code;
   endfunction

endpackage

`default_nettype wire

>>> rtl/b64se_if.sv
// Valid/ready channel interfaces for the encoder's byte input and character output.
// Depends on nothing.
`default_nettype none

interface b64se_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64se_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] char_code;
   logic       final_char;

   modport source (output valid, output char_code, output final_char, input ready);
   modport sink   (input valid, input char_code, input final_char, output ready);
endinterface

`default_nettype wire

>>> rtl/b64se_front.sv
// Front end: takes bytes, tracks group phase and leftover bits, builds character jobs.
// Depends on b64se_pkg and b64se_if.
`default_nettype none

module b64se_front (
   input  wire                 clock,
   input  wire                 reset,
   b64se_req_if.sink           req,
   input  wire                 queue_ready,
   output logic                push,
   output b64se_pkg::job_type  job
);

   b64se_pkg::phase_type    phase_ff, phase_in;
   b64se_pkg::leftover_type leftover_ff, leftover_in;
   b64se_pkg::byte_type     b;
   logic                    fin;

   assign req.ready = queue_ready;
   assign push      = req.valid && queue_ready;
   assign b         = req.data_byte;
   assign fin       = req.final_byte;

   always_comb begin
      job.codes     = {4{b64se_pkg::CHAR_PAD}};
      job.last_slot = 2'd0;
      job.fin       = fin;
      phase_in      = phase_ff;
      leftover_in   = leftover_ff;
      unique case (phase_ff)
         b64se_pkg::PHASE_SECOND: begin
            job.codes[0] = b64se_pkg::sym({leftover_ff[1:0], b[7:4]});
            phase_in     = b64se_pkg::PHASE_THIRD;
            leftover_in  = b[3:0];
            if (fin) begin
               job.codes[1]  = b64se_pkg::sym({b[3:0], 2'b00});
               job.last_slot = 2'd2;
            end
         end
         b64se_pkg::PHASE_THIRD: begin
            job.codes[0]  = b64se_pkg::sym({leftover_ff, b[7:6]});
            job.codes[1]  = b64se_pkg::sym(b[5:0]);
            job.last_slot = 2'd1;
            phase_in      = b64se_pkg::PHASE_FIRST;
            leftover_in   = 4'd0;
         end
         default: begin
            // first byte of a group, also the unused phase code
            job.codes[0] = b64se_pkg::sym(b[7:2]);
            phase_in     = b64se_pkg::PHASE_SECOND;
            leftover_in  = {2'b00, b[1:0]};
            if (fin) begin
               job.codes[1]  = b64se_pkg::sym({b[1:0], 4'b0000});
               job.last_slot = 2'd3;
            end
         end
      endcase
      if (fin) begin
         phase_in    = b64se_pkg::PHASE_FIRST;
         leftover_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= b64se_pkg::PHASE_FIRST;
         leftover_ff <= 4'd0;
      end else if (push) begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

   a_end_clears_state : assert property (@(posedge clock) disable iff (reset)
      (push && fin) |=> (phase_ff == b64se_pkg::PHASE_FIRST && leftover_ff == 4'd0))
      else $error("state not cleared after last byte");

endmodule

`default_nettype wire

>>> rtl/b64se_queue.sv
// Short FIFO of character jobs between the front end and the serializer.
// Depends on b64se_pkg.
`default_nettype none

module b64se_queue #(
   parameter int DEPTH = 2
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  b64se_pkg::job_type  in_job,
   output logic                out_valid,
   input  wire                 out_ready,
   output b64se_pkg::job_type  out_job
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64se_pkg::job_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= in_job;
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_ptr_gap : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

>>> rtl/b64se_back.sv
// Back end: walks the characters of each job into the registered output, one a cycle unless the output stalls.
// Depends on b64se_pkg.
`default_nettype none

module b64se_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 job_valid,
   output logic                job_ready,
   input  b64se_pkg::job_type  job,
   output logic                out_valid,
   input  wire                 out_ready,
   output b64se_pkg::char_type out_code,
   output logic                out_final
);

   b64se_pkg::job_type  cur_ff;
   b64se_pkg::slot_type slot_ff;
   logic                busy_ff;
   logic                out_valid_ff;
   b64se_pkg::char_type out_code_ff;
   logic                out_final_ff;
   logic                out_load, emit, emit_last, take;

   assign out_load  = !out_valid_ff || out_ready;
   assign emit      = busy_ff && out_load;
   assign emit_last = emit && (slot_ff == cur_ff.last_slot);
   assign job_ready = !busy_ff || emit_last;
   assign take      = job_valid && job_ready;

   assign out_valid = out_valid_ff;
   assign out_code  = out_code_ff;
   assign out_final = out_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         slot_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (take)           busy_ff <= 1'b1;
         else if (emit_last) busy_ff <= 1'b0;
         if (take)      slot_ff <= '0;
         else if (emit) slot_ff <= slot_ff + 1'b1;
         if (emit)           out_valid_ff <= 1'b1;
         else if (out_ready) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) cur_ff <= job;
      if (emit) begin
         out_code_ff  <= cur_ff.codes[slot_ff];
         out_final_ff <= cur_ff.fin && emit_last;
      end
   end

   a_slot_bound : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (slot_ff <= cur_ff.last_slot))
      else $error("character slot past end of job");

endmodule

`default_nettype wire

>>> rtl/base64_stream_encoder_core.sv
// Top level of the Base64 stream encoder: front end, job queue and serializer.
// Depends on b64se_pkg, b64se_if, b64se_front, b64se_queue and b64se_back.
`default_nettype none

// Standard Base64 encoder for a byte stream. Feed the message one byte per req item
// and raise final_byte on its last byte; each rsp item is one 7-bit ASCII character
// of the alphabet or '=', and final_char marks the last character of the message.
// A byte yields one or two characters; the last byte also flushes the open group
// with zero bits and up to two pad characters, so it yields two to four. The front
// end takes a byte in any cycle in which the job queue (QUEUE_DEPTH entries) has
// room, and the serializer behind it sends one character per cycle unless rsp.ready
// holds it back. The single character output register limits the throughput of a
// long message. The first character of a byte goes from the queue entry through the
// serializer's job register into the output register, which it leaves when taken.
// Both sides stall independently; the output register holds while rsp.ready is low.
module base64_stream_encoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire         clock,
   input  wire         reset,
   b64se_req_if.sink   req,
   b64se_rsp_if.source rsp
);

   // Job handoff between the stages
   logic               push, queue_ready;
   b64se_pkg::job_type front_job;
   logic               job_valid, job_ready;
   b64se_pkg::job_type queue_job;

   // Classify each byte by group phase and build its characters
   b64se_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .queue_ready (queue_ready),
      .push        (push),
      .job         (front_job)
   );

   // Decouple byte intake from character output
   b64se_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (queue_ready),
      .in_job    (front_job),
      .out_valid (job_valid),
      .out_ready (job_ready),
      .out_job   (queue_job)
   );

   // Send characters one per cycle through the output register unless rsp.ready stalls it
   b64se_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_ready (job_ready),
      .job       (queue_job),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_code  (rsp.char_code),
      .out_final (rsp.final_char)
   );

endmodule

`default_nettype wire
